FILE: rtl/core/amk_pkg.sv
// Shared types, codes and the Morse lookup table for the ASCII to Morse keyer.
package amk_pkg;

    localparam int UNIT_W = 16;
    localparam int MARK_W = 18;
    localparam int GAP_W  = 19;
    localparam int SYM_W  = 7;
    localparam int CNT_W  = 3;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;
    localparam logic [6:0]        SPACE_CODE = 7'h20;

    typedef enum logic [1:0] {
        KIND_DOT  = 2'd0,
        KIND_DASH = 2'd1,
        KIND_WORD = 2'd2
    } kind_t;

    // Decoded character: symbols left-aligned, sent from bit 6 down.
    typedef struct packed {
        logic             is_space;
        logic [CNT_W-1:0] count;
        logic [SYM_W-1:0] syms;
    } amk_dec_t;

    // bit 7 = padding polarity, bits 6..0 = padded symbols (1 dash, 0 dot)
    localparam logic [7:0] MORSE_TABLE [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'hC5, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'hF5, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hEA,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h2B, 8'hD2, 8'h00, 8'h00, 8'h00, 8'hE8, 8'hDE,
        8'h16, 8'h2D, 8'h00, 8'hEA, 8'h33, 8'h21, 8'hD5, 8'h12,
        8'h1F, 8'hEF, 8'hE7, 8'hE3, 8'hE1, 8'hE0, 8'h10, 8'h18,
        8'h1C, 8'h1E, 8'h38, 8'h00, 8'h00, 8'h11, 8'h00, 8'hCC,
        8'hDA, 8'hFD, 8'h08, 8'h0A, 8'h04, 8'hFE, 8'hF2, 8'h06,
        8'hF0, 8'hFC, 8'hF7, 8'h05, 8'hF4, 8'h03, 8'h02, 8'h07,
        8'hF6, 8'h0D, 8'hFA, 8'hF8, 8'h01, 8'hF9, 8'hF1, 8'hFB,
        8'h09, 8'h0B, 8'h0C, 8'hF5, 8'hEA, 8'hE8, 8'h45, 8'h11,
        8'hC5, 8'hFD, 8'h08, 8'h0A, 8'h04, 8'hFE, 8'hF2, 8'h06,
        8'hF0, 8'hFC, 8'hF7, 8'h05, 8'hF4, 8'h03, 8'h02, 8'h07,
        8'hF6, 8'h0D, 8'hFA, 8'hF8, 8'h01, 8'hF9, 8'hF1, 8'hFB,
        8'h09, 8'h0B, 8'h0C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

FILE: rtl/core/ascii_to_morse_keyer.sv
// Top level of the ASCII to Morse keyer: input stage, decode stage, emitter, output register.
//
// A character is taken when start is high and busy is low. It passes the input register,
// the decode register, the emitter and the output register; its first symbol beat is marked
// on the result ports by symbol_strobe for one cycle, and the remaining symbols follow on
// consecutive cycles, the final one flagged by last. A space gives one word-gap beat; a
// character with no Morse form gives none. The emitter sends one symbol per cycle and sets
// the sustained rate; the two stages in front of it keep accepting until they are full, then
// busy rises. Results cannot be held off. The user must write unit_ms through cfg_we /
// cfg_data only while no character is in flight; the block itself does not enforce this.
module ascii_to_morse_keyer
    import amk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        ascii_code,
    input  logic              cfg_we,
    input  logic [UNIT_W-1:0] cfg_data,
    output logic              symbol_strobe,
    output logic [1:0]        symbol_kind,
    output logic [MARK_W-1:0] mark_ms,
    output logic [GAP_W-1:0]  gap_ms,
    output logic              last
);

    logic              unit_reg_en;
    logic [UNIT_W-1:0] unit_reg;
    logic [MARK_W-1:0] unit3_reg;
    logic [GAP_W-1:0]  unit7_reg;

    logic              s1_valid_reg;
    logic [6:0]        s1_ch_reg;
    logic              s2_valid_reg;
    amk_dec_t          s2_dec_reg;
    amk_dec_t          s1_dec;

    logic [CNT_W-1:0]  s3_cnt_reg;
    logic [CNT_W-1:0]  s3_cnt_next;
    logic [SYM_W-1:0]  s3_sym_reg;
    logic [SYM_W-1:0]  s3_sym_next;
    logic              s3_space_reg;
    logic              s3_space_next;

    logic              strobe_reg;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [MARK_W-1:0] mark_reg;
    logic [MARK_W-1:0] mark_next;
    logic [GAP_W-1:0]  gap_reg;
    logic [GAP_W-1:0]  gap_next;
    logic              last_reg;

    logic accept;
    logic s3_load;
    logic s2_take;
    logic emit;

    assign unit_reg_en = cfg_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg  <= UNIT_RESET;
            unit3_reg <= MARK_W'(UNIT_RESET) * MARK_W'(3);
            unit7_reg <= GAP_W'(UNIT_RESET) * GAP_W'(7);
        end
        else
        begin
            if (unit_reg_en)
            begin
                unit_reg <= cfg_data;
            end
            unit3_reg <= {1'b0, unit_reg, 1'b0} + MARK_W'(unit_reg);
            unit7_reg <= {unit_reg, 3'b000} - GAP_W'(unit_reg);
        end
    end

    // flow control
    assign emit    = (s3_cnt_reg != '0);
    assign s3_load = (s3_cnt_reg <= CNT_W'(1));
    assign s2_take = !s2_valid_reg || s3_load;
    assign busy    = s1_valid_reg && !s2_take;
    assign accept  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_take)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (!busy)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg <= ascii_code[6:0];
        end
        if (s2_take && s1_valid_reg)
        begin
            s2_dec_reg <= s1_dec;
        end
    end

    amk_decode u_decode
    (
        .ch  (s1_ch_reg),
        .dec (s1_dec)
    );

    // emitter: one symbol per beat from bit 6
    always_comb
    begin
        if (s3_load)
        begin
            s3_cnt_next   = s2_valid_reg ? s2_dec_reg.count : '0;
            s3_sym_next   = s2_dec_reg.syms;
            s3_space_next = s2_dec_reg.is_space;
        end
        else
        begin
            s3_cnt_next   = s3_cnt_reg - CNT_W'(1);
            s3_sym_next   = s3_sym_reg << 1;
            s3_space_next = s3_space_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_cnt_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            s3_cnt_reg <= s3_cnt_next;
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_sym_reg   <= s3_sym_next;
        s3_space_reg <= s3_space_next;
    end

    always_comb
    begin
        if (s3_space_reg)
        begin
            kind_next = KIND_WORD;
            mark_next = '0;
            gap_next  = unit7_reg;
        end
        else if (s3_sym_reg[SYM_W-1])
        begin
            kind_next = KIND_DASH;
            mark_next = unit3_reg;
            gap_next  = GAP_W'(unit_reg);
        end
        else
        begin
            kind_next = KIND_DOT;
            mark_next = MARK_W'(unit_reg);
            gap_next  = GAP_W'(unit_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            mark_reg <= mark_next;
            gap_reg  <= gap_next;
            last_reg <= (s3_cnt_reg == CNT_W'(1));
        end
    end

    assign symbol_strobe = strobe_reg;
    assign symbol_kind   = kind_reg;
    assign mark_ms       = mark_reg;
    assign gap_ms        = gap_reg;
    assign last          = last_reg;

endmodule

FILE: rtl/core/amk_decode.sv
// Table lookup, padding strip and left alignment of one character's symbols.
module amk_decode
    import amk_pkg::*;
(
    input  logic [6:0] ch,
    output amk_dec_t   dec
);

    logic [7:0]       code;
    logic             pad;
    logic [CNT_W-1:0] count;

    always_comb
    begin
        code  = MORSE_TABLE[ch];
        pad   = code[7];
        count = '0;
        // highest bit differing from the padding wins
        for (int i = 0; i < SYM_W; i++)
        begin
            if (code[i] != pad)
            begin
                count = CNT_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        dec.is_space = (ch == SPACE_CODE);
        if (dec.is_space)
        begin
            dec.count = CNT_W'(1);
            dec.syms  = '0;
        end
        else
        begin
            dec.count = count;
            dec.syms  = code[6:0] << (CNT_W'(SYM_W) - count);
        end
    end

endmodule

FILE: rtl/core/amk_checker.sv
// Port-level checks on the ASCII to Morse keyer, bound to the top level.
module amk_checker
    import amk_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              symbol_strobe,
    input logic [1:0]        symbol_kind,
    input logic [MARK_W-1:0] mark_ms,
    input logic [GAP_W-1:0]  gap_ms,
    input logic              last
);

    // a word gap is a single, final, dark beat
    a_word_gap: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_strobe && symbol_kind == KIND_WORD |-> last && mark_ms == '0)
        else $error("word gap beat malformed");

    // dash lasts three gaps
    a_dash_len: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_strobe && symbol_kind == KIND_DASH |-> GAP_W'(mark_ms) == gap_ms * GAP_W'(3))
        else $error("dash length not three units");

    a_dot_len: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_strobe && symbol_kind == KIND_DOT |-> GAP_W'(mark_ms) == gap_ms)
        else $error("dot length not one unit");

    // symbols of one character come on consecutive beats
    a_no_hole: assert property (@(posedge clk) disable iff (!rst_n)
        symbol_strobe && !last |=> symbol_strobe)
        else $error("character train broken");

endmodule

bind ascii_to_morse_keyer amk_checker u_amk_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .symbol_strobe (symbol_strobe),
    .symbol_kind   (symbol_kind),
    .mark_ms       (mark_ms),
    .gap_ms        (gap_ms),
    .last          (last)
);

FILE: test/tb_ascii_to_morse_keyer.sv
// Self-checking testbench for ascii_to_morse_keyer: directed table then random characters.
`timescale 1ns / 1ps

module tb_ascii_to_morse_keyer;
    import amk_pkg::*;

    localparam int SETTLE     = 16;
    localparam int STALL_MAX  = 2000;
    localparam int N_ROWS     = 24;
    localparam int PHASE_LEN  = 25;

    typedef struct {
        kind_t             kind;
        logic [MARK_W-1:0] mark;
        logic [GAP_W-1:0]  gap;
        logic              last;
    } symbol_t;

    // typed rows carry their answer in units; has_sym = 0 means no beat at all
    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        logic       has_sym;
        kind_t      kind;
        logic [2:0] mark_u;
        logic [2:0] gap_u;
    } char_row_t;

    localparam char_row_t CHAR_ROWS [N_ROWS] = '{
        '{8'h20, 1'b1, 1'b1, KIND_WORD, 3'd0, 3'd7},
        '{8'hA0, 1'b1, 1'b1, KIND_WORD, 3'd0, 3'd7},
        '{8'h00, 1'b1, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h80, 1'b1, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'hFF, 1'b1, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h7B, 1'b1, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h45, 1'b1, 1'b1, KIND_DOT,  3'd1, 3'd1},
        '{8'hC5, 1'b1, 1'b1, KIND_DOT,  3'd1, 3'd1},
        '{8'h54, 1'b1, 1'b1, KIND_DASH, 3'd3, 3'd1},
        '{8'h5E, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'hDE, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h30, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h35, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h41, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h3F, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h04, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h0A, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h0B, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h17, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h61, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h7A, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h2E, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h22, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0},
        '{8'h5F, 1'b0, 1'b0, KIND_DOT,  3'd0, 3'd0}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [7:0]        ascii_code;
    logic              cfg_we;
    logic [UNIT_W-1:0] cfg_data;
    logic              symbol_strobe;
    logic [1:0]        symbol_kind;
    logic [MARK_W-1:0] mark_ms;
    logic [GAP_W-1:0]  gap_ms;
    logic              last;

    symbol_t           pending_syms [$];
    logic [UNIT_W-1:0] unit_now;
    int                mismatches = 0;
    int                chars_sent;
    int                beats_checked = 0;
    int                stall_cycles = 0;

    ascii_to_morse_keyer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .ascii_code    (ascii_code),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .symbol_strobe (symbol_strobe),
        .symbol_kind   (symbol_kind),
        .mark_ms       (mark_ms),
        .gap_ms        (gap_ms),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void predict_morse(input logic [7:0] code);
        logic [6:0] ch;
        logic [7:0] pattern;
        int         first;
        int         b;
        symbol_t    s;
        ch = code[6:0];
        if (ch == SPACE_CODE)
        begin
            s.kind = KIND_WORD;
            s.mark = '0;
            s.gap  = GAP_W'(7 * unit_now);
            s.last = 1'b1;
            pending_syms.push_back(s);
            return;
        end
        pattern = MORSE_TABLE[ch];
        first   = -1;
        for (b = 6; b >= 0; b--)
            if (first < 0 && pattern[b] != pattern[7])
                first = b;
        for (b = first; b >= 0; b--)
        begin
            s.kind = pattern[b] ? KIND_DASH : KIND_DOT;
            s.mark = pattern[b] ? MARK_W'(3 * unit_now) : MARK_W'(unit_now);
            s.gap  = GAP_W'(unit_now);
            s.last = (b == 0);
            pending_syms.push_back(s);
        end
    endfunction

    task automatic send_char(input logic [7:0] code);
        start      <= 1'b1;
        ascii_code <= code;
        do
            @(posedge clk);
        while (busy);
        chars_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_syms.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_unit(input logic [UNIT_W-1:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        unit_now = value;
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int          r;
        logic [7:0]  c;
        r = $urandom_range(0, 99);
        if (r < 20)
            c = 8'($urandom_range(8'h41, 8'h5A));
        else if (r < 40)
            c = 8'($urandom_range(8'h61, 8'h7A));
        else if (r < 55)
            c = 8'($urandom_range(8'h30, 8'h39));
        else if (r < 70)
            c = 8'h20;
        else
            c = 8'($urandom_range(0, 255));
        if (r < 70)
            c[7] = 1'($urandom_range(0, 1));
        return c;
    endfunction

    always @(posedge clk)
    begin : result_check
        symbol_t e;
        if (rst_n && symbol_strobe)
        begin
            if (pending_syms.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected beat: kind %0d mark %0d gap %0d last %0d",
                             symbol_kind, mark_ms, gap_ms, last);
                mismatches++;
            end
            else
            begin
                e = pending_syms.pop_front();
                beats_checked++;
                if (symbol_kind != e.kind || mark_ms != e.mark || gap_ms != e.gap
                    || last != e.last)
                begin
                    if (mismatches < 10)
                        $display({"beat mismatch: got kind %0d mark %0d gap %0d last %0d,",
                                  " exp kind %0d mark %0d gap %0d last %0d"},
                                 symbol_kind, mark_ms, gap_ms, last,
                                 e.kind, e.mark, e.gap, e.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || symbol_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_MAX);
            $display("tb_ascii_to_morse_keyer NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        symbol_t           s;
        char_row_t         row;
        logic [UNIT_W-1:0] units [5];
        logic              no_gaps;
        int                i;
        int                p;

        rst_n         = 1'b0;
        start         = 1'b0;
        ascii_code    = '0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        unit_now      = UNIT_RESET;
        chars_sent    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset value of the unit first, then gapped and back-to-back
        for (i = 0; i < N_ROWS; i++)
        begin
            row = CHAR_ROWS[i];
            send_char(row.code);
            if (!row.typed)
                predict_morse(row.code);
            else if (row.has_sym)
            begin
                s.kind = row.kind;
                s.mark = MARK_W'(row.mark_u * unit_now);
                s.gap  = GAP_W'(row.gap_u * unit_now);
                s.last = 1'b1;
                pending_syms.push_back(s);
            end
            hold_off((i % 3 == 0) ? 0 : $urandom_range(0, 13));
        end

        units[0] = 16'd1;
        units[1] = 16'hFFFF;
        units[2] = 16'd0;
        units[3] = 16'($urandom_range(2, 200));
        units[4] = 16'($urandom_range(0, 65535));
        for (p = 0; p < 5; p++)
        begin
            write_unit(units[p]);
            no_gaps = 1'b0;
            for (i = 0; i < PHASE_LEN; i++)
            begin
                if (i % 10 == 0)
                    no_gaps = $urandom_range(0, 2) == 0;
                if (i == 15)
                    drain();
                send_char(pick_char());
                predict_morse(ascii_code);
                hold_off(no_gaps ? 0 : $urandom_range(0, 13));
            end
        end

        drain();
        $display("%0d characters, %0d beats checked; units 100, 1, 65535, 0, %0d and %0d",
                 chars_sent, beats_checked, units[3], units[4]);
        if (mismatches == 0 && pending_syms.size() == 0)
            $display("tb_ascii_to_morse_keyer OK");
        else
        begin
            $display("%0d mismatches, %0d beats never arrived", mismatches, pending_syms.size());
            $display("tb_ascii_to_morse_keyer NOT OK");
        end
        $finish;
    end

endmodule
